// ===== rtl/core/sita_pkg.sv =====
// ----------------------------------------------------------------------------
// sita_pkg
// Shared types and constants for the signed integer to decimal text core.
// ----------------------------------------------------------------------------
package sita_pkg;

  localparam int unsigned ValueW       = 32;
  localparam int unsigned CharW        = 8;
  localparam int unsigned DigitW       = 4;
  localparam int unsigned MaxDigits    = 10;
  localparam int unsigned NdigW        = 4;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [CharW-1:0]  DigitBase  = 8'd48;
  localparam logic [CharW-1:0]  MinusChar  = 8'd45;
  localparam logic [ValueW-1:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int unsigned       RecipShift = 35;

  // One converted number: sign, digit count and digits, least significant first.
  typedef struct packed {
    logic                                neg;
    logic [NdigW-1:0]                    ndig;
    logic [MaxDigits-1:0][DigitW-1:0]    digits;
  } sita_rec_t;

endpackage

// ===== rtl/core/signed_int_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a 32-bit signed integer into its decimal ASCII characters.
// ----------------------------------------------------------------------------
// Channel   Ports                          Transfer
// input     start, value_i, busy           start && !busy
// result    valid_o, character_o, last_o   valid_o, one cycle, no backpressure
//
// The converter registers each input, then yields one digit a cycle from the
// single reciprocal multiply.
// The serializer emits one character per cycle (up to 11 per number).
// A queue between them lets conversion of the next number overlap output.
// busy stays high while converting or while a converted number waits for room
// in the queue.
// Asynchronous active-low reset empties the queue and idles both sides.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core
  import sita_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
)(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [ValueW-1:0] value_i,
  output logic              busy,
  output logic              valid_o,
  output logic [CharW-1:0]  character_o,
  output logic              last_o
);

  logic      push, full, pop, empty;
  sita_rec_t rec_in, rec_out;

  sita_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .value_i (value_i),
    .busy_o  (busy),
    .full_i  (full),
    .push_o  (push),
    .rec_o   (rec_in)
  );

  sita_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (rec_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (rec_out)
  );

  sita_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .rec_i       (rec_out),
    .pop_o       (pop),
    .valid_o     (valid_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

// ===== rtl/core/sita_front.sv =====
// ----------------------------------------------------------------------------
// sita_front
// Takes a transaction, forms the magnitude and peels one decimal digit per
// cycle with a reciprocal multiply, then pushes the record to the queue.
// ----------------------------------------------------------------------------
module sita_front
  import sita_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ValueW-1:0] value_i,
  output logic              busy_o,
  input  logic              full_i,
  output logic              push_o,
  output sita_rec_t         rec_o
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SConv = 2'd1;
  localparam logic [1:0] SPush = 2'd2;

  logic [1:0]                       state_q, state_d;
  logic                             neg_q, neg_d;
  logic [ValueW-1:0]                mag_q, mag_d;
  logic [NdigW-1:0]                 cnt_q, cnt_d;
  logic [MaxDigits-1:0][DigitW-1:0] digits_q, digits_d;

  logic [2*ValueW-1:0] prod;
  logic [ValueW-1:0]   quot;
  logic [ValueW-1:0]   diff;
  logic                done;

  assign prod = (2*ValueW)'(mag_q) * (2*ValueW)'(RecipTen);
  assign quot = ValueW'(prod >> RecipShift);
  assign diff = mag_q - ((quot << 3) + (quot << 1));
  assign done = (quot == '0) || (cnt_q == NdigW'(MaxDigits - 1));

  always_comb begin
    state_d  = state_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    cnt_d    = cnt_q;
    digits_d = digits_q;
    push_o   = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          neg_d   = value_i[ValueW-1];
          mag_d   = value_i[ValueW-1] ? (ValueW'(0) - value_i) : value_i;
          cnt_d   = '0;
          state_d = SConv;
        end
      end
      SConv: begin
        digits_d[cnt_q] = diff[DigitW-1:0];
        mag_d           = quot;
        cnt_d           = cnt_q + NdigW'(1);
        if (done) begin
          if (!full_i) begin
            push_o  = 1'b1;
            state_d = SIdle;
          end else begin
            state_d = SPush;
          end
        end
      end
      SPush: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  assign busy_o      = (state_q != SIdle);
  assign rec_o.neg    = neg_q;
  assign rec_o.ndig   = cnt_d;
  assign rec_o.digits = digits_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    cnt_q    <= cnt_d;
    digits_q <= digits_d;
  end

endmodule

// ===== rtl/core/sita_fifo.sv =====
// ----------------------------------------------------------------------------
// sita_fifo
// Small register queue between the converter and the character serializer.
// ----------------------------------------------------------------------------
module sita_fifo
  import sita_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
)(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sita_rec_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output sita_rec_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sita_rec_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/sita_back.sv =====
// ----------------------------------------------------------------------------
// sita_back
// Character serializer: sign first, then digits most significant first.
// ----------------------------------------------------------------------------
module sita_back
  import sita_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  sita_rec_t        rec_i,
  output logic             pop_o,
  output logic             valid_o,
  output logic [CharW-1:0] character_o,
  output logic             last_o
);

  logic                             have_q, have_d;
  logic                             sign_q, sign_d;
  logic [NdigW-1:0]                 idx_q, idx_d;
  logic [MaxDigits-1:0][DigitW-1:0] digits_q, digits_d;
  logic                             finish;

  assign finish = have_q && !sign_q && (idx_q == '0);
  assign pop_o  = !empty_i && (!have_q || finish);

  always_comb begin
    have_d   = have_q;
    sign_d   = sign_q;
    idx_d    = idx_q;
    digits_d = digits_q;
    if (have_q) begin
      if (sign_q) begin
        sign_d = 1'b0;
      end else if (idx_q != '0) begin
        idx_d = idx_q - NdigW'(1);
      end else begin
        have_d = 1'b0;
      end
    end
    if (pop_o) begin
      have_d   = 1'b1;
      sign_d   = rec_i.neg;
      idx_d    = rec_i.ndig - NdigW'(1);
      digits_d = rec_i.digits;
    end
  end

  assign valid_o     = have_q;
  assign character_o = sign_q ? MinusChar : (DigitBase + CharW'(digits_q[idx_q]));
  assign last_o      = finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q   <= sign_d;
    idx_q    <= idx_d;
    digits_q <= digits_d;
  end

endmodule

// ===== rtl/core/sita_checker.sv =====
// ----------------------------------------------------------------------------
// sita_checker
// Port-level checks on the converter's character stream.
// ----------------------------------------------------------------------------
module sita_checker
  import sita_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              valid_o,
  input logic [CharW-1:0]  character_o,
  input logic              last_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (character_o == MinusChar ||
                 (character_o >= DigitBase && character_o <= DigitBase + 8'd9)))
    else $error("illegal character code");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && character_o == MinusChar) |-> !last_o)
    else $error("minus sign flagged last");

  a_minus_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && character_o == MinusChar) |=> (valid_o && character_o != MinusChar))
    else $error("minus sign not followed by a digit");

  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> valid_o)
    else $error("gap inside a number's text");

endmodule

bind signed_int_to_decimal_ascii_core sita_checker u_sita_checker (.*);
